FILE: design/assert_macros.svh
// assertion macros shared by the range value count design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check clocked on clk_i, disabled while rst_ni is low
`define RVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// concurrent check with an explicit clock and active-low reset
`define RVC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`endif

FILE: design/rvc_pkg.sv
// types and constants for the range value count core
package rvc_pkg;

  localparam int VAL_W       = 32;
  localparam int POS_W       = 11;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 16;

  localparam logic [POS_W-1:0] COUNT_MAX = '1;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // input request payload, first field in the lowest bits
  typedef struct packed {
    logic [IN_TDATA_W-2*POS_W-4*VAL_W+VAL_W-1:0] pad;
    logic signed [VAL_W-1:0]                     high_value;
    logic signed [VAL_W-1:0]                     low_value;
    logic [POS_W-1:0]                            last_pos;
    logic [POS_W-1:0]                            first_pos;
    logic signed [VAL_W-1:0]                     element_value;
  } rvc_in_data_t;

  // append request towards the element store
  typedef struct packed {
    logic             append;
    logic [VAL_W-1:0] value;
  } rvc_store_req_t;

endpackage

FILE: design/range_value_count_core.sv
// range value count core: element store and a scanning compare sequencer
// an append is taken while idle and the core stays ready for the next request
// a query over the clipped positions steps through scan, drain and finish before its result shows
// an empty query (no positions or low above high) skips scan and drain and goes straight to finish
// a result waiting on m_axis_tready holds the next query in finish until it is taken
// asynchronous active-low reset empties the store; no result is pending after reset
`include "assert_macros.svh"

module range_value_count_core #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // element_value, first_pos, last_pos, low_value, high_value, zero fill
  input  logic [rvc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // match_count, zero fill
  output logic [rvc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import rvc_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  rvc_in_data_t   in_data;
  rvc_store_req_t store_req;
  logic [VAL_W-1:0] rd_data;
  logic [CW-1:0]    loaded;

  logic [1:0]              state_q, state_d;
  logic [AW-1:0]           addr_q, addr_d;
  logic [AW-1:0]           end_q, end_d;
  logic signed [VAL_W-1:0] lo_q, lo_d;
  logic signed [VAL_W-1:0] hi_q, hi_d;
  logic [POS_W-1:0]        count_q, count_d;
  logic [POS_W-1:0]        out_cnt_q, out_cnt_d;
  logic                    rd_vld_q, out_vld_q, out_vld_d;

  logic          in_acc;
  logic          hit;
  logic          empty_c;
  logic [PW-1:0] first_c, last_c, start_w, stop_w;

  assign in_data       = rvc_in_data_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign store_req.append = in_acc && (s_axis_tuser == OP_APPEND);
  assign store_req.value  = in_data.element_value;

  rvc_store #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (store_req),
    .rd_addr_i(addr_q),
    .rd_data_o(rd_data),
    .loaded_o (loaded)
  );

  // clip the position range to the loaded part of the store and flag an empty query
  always_comb begin
    first_c = PW'(in_data.first_pos);
    if (first_c == '0) begin
      first_c = PW'(1);
    end
    last_c = PW'(in_data.last_pos);
    if (last_c > PW'(loaded)) begin
      last_c = PW'(loaded);
    end
    start_w = first_c - PW'(1);
    stop_w  = last_c - PW'(1);
    empty_c = (first_c > last_c) || (in_data.low_value > in_data.high_value);
  end

  // shared range compare on the registered read data
  assign hit = rd_vld_q && ($signed(rd_data) >= lo_q) && ($signed(rd_data) <= hi_q);

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    end_d     = end_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    count_d   = count_q;
    out_cnt_d = out_cnt_q;
    out_vld_d = out_vld_q;

    if (hit && (count_q != COUNT_MAX)) begin
      count_d = count_q + POS_W'(1);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == OP_QUERY)) begin
          lo_d    = in_data.low_value;
          hi_d    = in_data.high_value;
          count_d = '0;
          addr_d  = start_w[AW-1:0];
          end_d   = stop_w[AW-1:0];
          state_d = empty_c ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_q == end_q) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_vld_q || m_axis_tready) begin
          out_cnt_d = count_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= (state_q == ST_SCAN);
      out_vld_q <= out_vld_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    end_q     <= end_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    out_cnt_q <= out_cnt_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-POS_W){1'b0}}, out_cnt_q};

  `RVC_ASSERT(a_scan_in_range, (state_q == ST_SCAN) |-> (addr_q <= end_q), "scan address past end")
  `RVC_ASSERT(a_count_bounded, PW'(count_q) <= PW'(loaded), "count exceeds loaded elements")
  `RVC_ASSERT(a_result_from_finish, $rose(m_axis_tvalid) |-> ($past(state_q) == ST_FINISH), "result raised outside finish")
  `RVC_ASSERT(a_append_grows, (store_req.append && (loaded < CW'(MAX_ELEMENTS))) |=> (loaded == $past(loaded) + CW'(1)), "append did not grow store")

endmodule

FILE: design/rvc_store.sv
// element store with append pointer, loaded count and registered read port
module rvc_store #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rvc_pkg::rvc_store_req_t            req_i,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]    rd_addr_i,
  output logic [rvc_pkg::VAL_W-1:0]          rd_data_o,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0]  loaded_o
);
  import rvc_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_ELEMENTS);

  logic [VAL_W-1:0] mem [MAX_ELEMENTS];
  logic [CW-1:0]    loaded_q, loaded_d;
  logic             wr_en;

  assign wr_en = req_i.append && (loaded_q < FULL);

  always_comb begin
    loaded_d = loaded_q;
    if (wr_en) begin
      loaded_d = loaded_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else begin
      loaded_q <= loaded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[loaded_q[AW-1:0]] <= req_i.value;
    end
    rd_data_o <= mem[rd_addr_i];
  end

  assign loaded_o = loaded_q;

endmodule
